/* hw/rtl/dlks_pkg.sv */
// shared constants and types of the draw list key sorter
package dlks_pkg;

   // capacity of the sorted row, legal range 2 to 64
   localparam int MAX_ITEMS = 64;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   localparam int HANDLE_W  = 32;
   localparam int KEY_W     = 64;
   localparam int IDX_W     = 6;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 72;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // key_mode codes
   localparam logic MODE_MATERIAL = 1'b0;
   localparam logic MODE_DEPTH    = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             final_item;
   } qentry_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } back_state_type;

endpackage

/* hw/rtl/draw_list_key_sorter.sv */
// top level of the draw list key sorter
//
//  channel  dir  handshake                tdata / sideband
//  req      in   req_tvalid/req_tready    tdata: material, mesh, depth; tlast: final_item
//  rsp      out  rsp_tvalid/rsp_tready    tdata: item_index, draw key; tlast; tuser: overflow
//  csr      in   csr_we                   csr_wdata: key_mode
//
// one item per cycle enters the sorted row while the queue holds items, no drain runs and the row has room;
// a 64 bit compare in every cell of the systolic row sets the cost of an insert
// a final item starts a drain of the n stored items, one result per cycle while
// rsp_tready is high; no item leaves the queue meanwhile, the queue takes up to 4 more
// reset is synchronous and active high, one cycle; no clearing pass is needed
// back pressure on rsp stalls only the drain, the front keeps filling the queue
module draw_list_key_sorter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_wdata,   // key_mode
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dlks_pkg::REQ_DATA_W-1:0]   req_tdata,   // material_handle, mesh_handle, depth_bits
   input  logic                              req_tlast,   // final_item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dlks_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // item_index, draw key, zero pad
   output logic                              rsp_tlast,   // last_result
   output logic                              rsp_tuser    // overflow
);
   import dlks_pkg::*;

   // front to queue
   logic       push_valid;
   logic       push_ready;
   qentry_type push_entry;

   // queue to back
   logic       pop_valid;
   logic       pop_ready;
   qentry_type pop_entry;

   // key build and mode register
   dlks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue, lets the front take items while the back drains
   dlks_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // sorted row, drain and result register
   dlks_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hw/rtl/dlks_front.sv */
// front end: key mode register and sort key build for each incoming item
module dlks_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dlks_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output dlks_pkg::qentry_type                 push_entry
);
   import dlks_pkg::*;

   logic                key_mode_ff;
   logic                key_mode_in;
   logic [HANDLE_W-1:0] material_handle;
   logic [HANDLE_W-1:0] mesh_handle;
   logic [HANDLE_W-1:0] depth_bits;

   assign key_mode_in = csr_we ? csr_wdata : key_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= MODE_MATERIAL;
      end else begin
         key_mode_ff <= key_mode_in;
      end
   end

   assign material_handle = req_tdata[HANDLE_W-1:0];
   assign mesh_handle     = req_tdata[2*HANDLE_W-1:HANDLE_W];
   assign depth_bits      = req_tdata[3*HANDLE_W-1:2*HANDLE_W];

   always_comb begin
      case (key_mode_ff)
         MODE_DEPTH: begin
            // inverted depth bits, back to front for positive depths
            push_entry.key = {{(KEY_W-HANDLE_W){1'b0}}, ~depth_bits};
         end
         default: begin
            push_entry.key = {material_handle, mesh_handle};
         end
      endcase
      push_entry.final_item = req_tlast;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

/* hw/rtl/dlks_queue.sv */
// short fifo of keyed items between the front end and the sorter
module dlks_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  dlks_pkg::qentry_type  push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output dlks_pkg::qentry_type  pop_entry
);
   import dlks_pkg::*;

   qentry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff;
   logic [QCNT_W-1:0] fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   fill_in = QCNT_W'(fill_ff + 1'b1);
         2'b01:   fill_in = QCNT_W'(fill_ff - 1'b1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hw/rtl/dlks_back.sv */
// back end: systolic insertion sorted row and ordered drain to the result register
module dlks_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  dlks_pkg::qentry_type               pop_entry,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dlks_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser
);
   import dlks_pkg::*;

   back_state_type       state_ff;
   back_state_type       state_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 ovf_ff;
   logic                 ovf_in;
   logic [CNT_W-1:0]     drain_left_ff;
   logic [CNT_W-1:0]     drain_left_in;
   logic                 run_ovf_ff;
   logic                 run_ovf_in;

   logic [KEY_W-1:0]     cell_key_ff [MAX_ITEMS];
   logic [KEY_W-1:0]     cell_key_in [MAX_ITEMS];
   logic [IDX_W-1:0]     cell_idx_ff [MAX_ITEMS];
   logic [IDX_W-1:0]     cell_idx_in [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] cell_vld_ff;
   logic [MAX_ITEMS-1:0] cell_vld_in;
   logic [MAX_ITEMS-1:0] ins;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic                 rsp_last_ff;
   logic                 rsp_ovf_ff;

   logic                 full;
   logic                 do_pop;
   logic                 do_store;
   logic                 drain_go;

   assign pop_ready = (state_ff == ST_LOAD);
   assign do_pop    = pop_valid && pop_ready;
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign do_store  = do_pop && !full;
   assign drain_go  = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_tready);

   // a new key goes in front of the first cell that is empty or holds a larger key
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         ins[i] = !cell_vld_ff[i] || (cell_key_ff[i] > pop_entry.key);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_key_in[i] = cell_key_ff[i];
         cell_idx_in[i] = cell_idx_ff[i];
         cell_vld_in[i] = cell_vld_ff[i];
         if (do_store) begin
            if (i > 0 && ins[i-1]) begin
               cell_key_in[i] = cell_key_ff[i-1];
               cell_idx_in[i] = cell_idx_ff[i-1];
               cell_vld_in[i] = cell_vld_ff[i-1];
            end else if (ins[i]) begin
               cell_key_in[i] = pop_entry.key;
               cell_idx_in[i] = IDX_W'(count_ff);
               cell_vld_in[i] = 1'b1;
            end
         end else if (drain_go) begin
            if (i < MAX_ITEMS - 1) begin
               cell_key_in[i] = cell_key_ff[i+1];
               cell_idx_in[i] = cell_idx_ff[i+1];
               cell_vld_in[i] = cell_vld_ff[i+1];
            end else begin
               cell_vld_in[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      drain_left_in = drain_left_ff;
      run_ovf_in    = run_ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (do_pop) begin
               if (pop_entry.final_item) begin
                  state_in      = ST_DRAIN;
                  drain_left_in = do_store ? CNT_W'(count_ff + 1'b1) : count_ff;
                  run_ovf_in    = ovf_ff || full;
                  count_in      = '0;
                  ovf_in        = 1'b0;
               end else begin
                  count_in = do_store ? CNT_W'(count_ff + 1'b1) : count_ff;
                  ovf_in   = ovf_ff || full;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_go) begin
               drain_left_in = CNT_W'(drain_left_ff - 1'b1);
               if (drain_left_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid_in = drain_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_key_ff[i] <= cell_key_in[i];
         cell_idx_ff[i] <= cell_idx_in[i];
      end
      if (drain_go) begin
         rsp_key_ff  <= cell_key_ff[0];
         rsp_idx_ff  <= cell_idx_ff[0];
         rsp_last_ff <= (drain_left_ff == CNT_W'(1));
         rsp_ovf_ff  <= run_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         drain_left_ff <= '0;
         run_ovf_ff    <= 1'b0;
         cell_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         drain_left_ff <= drain_left_in;
         run_ovf_ff    <= run_ovf_in;
         cell_vld_ff   <= cell_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-KEY_W-IDX_W){1'b0}}, rsp_key_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // a run being drained always has an entry left at the head of the row
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> drain_left_ff != '0 && cell_vld_ff[0])
      else $error("drain with empty row");

   // fill count stays within capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("fill count beyond capacity");

   // the head of the row is in order
   assert property (@(posedge clock) disable iff (reset)
      cell_vld_ff[1] |-> cell_vld_ff[0] && cell_key_ff[0] <= cell_key_ff[1])
      else $error("sorted row out of order");

   // no item is taken from the queue while a run drains
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> !do_pop)
      else $error("pop during drain");

endmodule

/* verif/draw_list_key_sorter_tb.sv */
// self-checking testbench of the draw list key sorter
`timescale 1ns / 100ps

module draw_list_key_sorter_tb;
   import dlks_pkg::*;

   // cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 4000;
   // quiet cycles after the last result, covers the queue and the sorted row
   localparam int SETTLE_CYCLES  = 20;
   // least number of items in each random phase
   localparam int PHASE_ITEMS    = 45;
   localparam int RANDOM_PHASES  = 8;

   typedef struct packed {
      logic [HANDLE_W-1:0] material;
      logic [HANDLE_W-1:0] mesh;
      logic [HANDLE_W-1:0] depth;
      logic                final_item;
   } draw_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] item_index;
      logic [KEY_W-1:0] draw_key;
      logic             last_result;
      logic             overflow;
   } sorted_draw_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic                  csr_wdata  = MODE_MATERIAL;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // material_handle, mesh_handle, depth_bits
   logic                  req_tlast  = 1'b0; // final_item
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // item_index, draw key, zero pad
   logic                  rsp_tlast;         // last_result
   logic                  rsp_tuser;         // overflow

   draw_list_key_sorter u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // items waiting to be sent, filled by the sequence below
   draw_item_type   draw_list_q[$];
   // expected sorted results, oldest first
   sorted_draw_type sorted_runs[$];

   // shadow of the sorter: keys of the list being loaded, in arrival order
   logic [KEY_W-1:0] row_keys[$];
   logic             row_dropped = 1'b0;
   logic             mode_shadow = MODE_MATERIAL;

   int  mismatch_count = 0;
   int  send_gap       = 0;
   int  hold_left      = 0;
   int  idle_cycles    = 0;
   int  cycle_count    = 0;
   // stretches where neither side idles
   logic steady        = 1'b0;

   // gap length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // handles: a quarter from a tiny set so that keys collide
   function automatic logic [HANDLE_W-1:0] rand_handle();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // depths: mostly positive floats, some ties, some raw bit patterns
   function automatic logic [HANDLE_W-1:0] rand_depth();
      logic [HANDLE_W-1:0] d;
      case ($urandom_range(0, 9))
         0, 1: d = 32'h3F80_0000 + $urandom_range(0, 2);
         2, 3, 4: d = $urandom;
         default: d = {1'b0, 8'($urandom_range(100, 140)), 23'($urandom)};
      endcase
      return d;
   endfunction

   task automatic add_item(input logic [HANDLE_W-1:0] material,
                           input logic [HANDLE_W-1:0] mesh,
                           input logic [HANDLE_W-1:0] depth,
                           input logic final_item);
      draw_item_type it;
      it.material   = material;
      it.mesh       = mesh;
      it.depth      = depth;
      it.final_item = final_item;
      draw_list_q.push_back(it);
   endtask

   // a list of random items, closed by a final item unless left open
   task automatic add_random_list(input int len, input bit closed);
      for (int i = 0; i < len; i++)
         add_item(rand_handle(), rand_handle(), rand_depth(), closed && (i == len - 1));
   endtask

   // key_mode write, only called with no item or result in flight
   task automatic write_key_mode(input logic mode);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // wait until every queued item went in and every result came out
   task automatic drain_phase();
      do
         @(posedge clock);
      while (draw_list_q.size() != 0 || req_tvalid || sorted_runs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void report_mismatch(input string what, input sorted_draw_type want,
                                           input sorted_draw_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s", $realtime, what);
         $display("   expected idx %0d key %h last %b ovf %b",
                  want.item_index, want.draw_key, want.last_result, want.overflow);
         $display("   got      idx %0d key %h last %b ovf %b",
                  got.item_index, got.draw_key, got.last_result, got.overflow);
      end
   endfunction

   // random gap windows: roughly one window in four runs without any idling
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 150 == 0)
         steady <= ($urandom_range(0, 3) == 0);
   end

   // request driver: holds an item until accepted, then takes the next one
   always @(posedge clock) begin
      draw_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap   = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (draw_list_q.size() != 0) begin
            nxt = draw_list_q.pop_front();
            req_tdata  <= {nxt.depth, nxt.mesh, nxt.material};
            req_tlast  <= nxt.final_item;
            req_tvalid <= 1'b1;
            if (!steady && $urandom_range(0, 2) == 0)
               send_gap = idle_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 5) == 0)
            hold_left = idle_len();
      end
   end

   // monitor: shadow sorter on accepted items, compare accepted results
   always @(posedge clock) begin
      draw_item_type    it;
      sorted_draw_type  got;
      sorted_draw_type  want;
      sorted_draw_type  run[$];
      sorted_draw_type  entry;
      logic [KEY_W-1:0] key;
      int               j;
      if (!reset) begin
         if (csr_we)
            mode_shadow = csr_wdata;

         if (rsp_tvalid && rsp_tready) begin
            got.item_index  = rsp_tdata[IDX_W-1:0];
            got.draw_key    = rsp_tdata[IDX_W +: KEY_W];
            got.last_result = rsp_tlast;
            got.overflow    = rsp_tuser;
            if (sorted_runs.size() == 0) begin
               report_mismatch("result with nothing expected", '0, got);
            end else begin
               want = sorted_runs.pop_front();
               if (got !== want)
                  report_mismatch("result mismatch", want, got);
            end
         end

         if (req_tvalid && req_tready) begin
            it.material   = req_tdata[HANDLE_W-1:0];
            it.mesh       = req_tdata[HANDLE_W +: HANDLE_W];
            it.depth      = req_tdata[2*HANDLE_W +: HANDLE_W];
            it.final_item = req_tlast;
            // key is fixed by the mode in force when the item arrives
            if (mode_shadow == MODE_DEPTH)
               key = {{(KEY_W-HANDLE_W){1'b0}}, ~it.depth};
            else
               key = {it.material, it.mesh};
            // full row: the item is dropped, a final one still triggers output
            if (row_keys.size() < MAX_ITEMS)
               row_keys.push_back(key);
            else
               row_dropped = 1'b1;

            if (it.final_item) begin
               run = {};
               // stable insertion: an equal key goes behind the earlier ones
               for (int i = 0; i < row_keys.size(); i++) begin
                  j = 0;
                  while (j < run.size() && run[j].draw_key <= row_keys[i])
                     j++;
                  entry.item_index  = IDX_W'(i);
                  entry.draw_key    = row_keys[i];
                  entry.last_result = 1'b0;
                  entry.overflow    = row_dropped;
                  run.insert(j, entry);
               end
               for (int i = 0; i < run.size(); i++) begin
                  entry = run[i];
                  entry.last_result = (i == run.size() - 1);
                  sorted_runs.push_back(entry);
               end
               row_keys    = {};
               row_dropped = 1'b0;
            end
         end
      end
   end

   // watchdog on cycles without any handshake or register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase_items;
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // material keys: lone final item at the top of the range
      write_key_mode(MODE_MATERIAL);
      add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
      // handle extremes and equal keys, which must keep arrival order
      add_item(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      add_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 1'b0);
      add_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_item(32'h0000_0001, 32'h0000_0005, 32'h0, 1'b0);
      add_item(32'h0000_0001, 32'h0000_0005, 32'h1234_5678, 1'b0);
      add_item(32'h0000_0000, 32'h0000_0000, 32'h0, 1'b0);
      add_item(32'h8000_0000, 32'h0000_0007, 32'h0, 1'b1);
      drain_phase();

      // depth keys: ordinary floats, zero, all ones, infinity, negative zero, a tie
      write_key_mode(MODE_DEPTH);
      add_item($urandom, $urandom, 32'h3F80_0000, 1'b0);
      add_item($urandom, $urandom, 32'h4000_0000, 1'b0);
      add_item($urandom, $urandom, 32'h0000_0000, 1'b0);
      add_item($urandom, $urandom, 32'hFFFF_FFFF, 1'b0);
      add_item($urandom, $urandom, 32'h7F80_0000, 1'b0);
      add_item($urandom, $urandom, 32'h3F80_0000, 1'b0);
      add_item($urandom, $urandom, 32'h8000_0000, 1'b1);
      // mode change in the middle of a list: stored keys keep their depth form
      add_item(32'h0, 32'h0, 32'h3F80_0000, 1'b0);
      add_item(32'h0, 32'h0, 32'h3F00_0000, 1'b0);
      drain_phase();
      write_key_mode(MODE_MATERIAL);
      add_item(32'h0000_0000, 32'h0000_0001, 32'h0, 1'b0);
      add_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 1'b0);
      add_item(32'h0000_0000, 32'h0000_0000, 32'h0, 1'b1);
      drain_phase();

      // random phases, alternating key modes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_key_mode(p[0] ? MODE_DEPTH : MODE_MATERIAL);
         phase_items = 0;
         // full row cases: two lists with dropped items and a dropped final, the second behind the
         // items left open before it, and a list that exactly fills the row
         if (p == 1 || p == 3 || p == 5) begin
            len = (p == 1) ? MAX_ITEMS + 3 : (p == 3) ? MAX_ITEMS + 1 : MAX_ITEMS;
            add_random_list(len, 1'b1);
            phase_items += len;
         end
         while (phase_items < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6)
                                              : $urandom_range(1, 12);
            add_random_list(len, 1'b1);
            phase_items += len;
         end
         // leave a list open so the next phase finishes it under the other mode
         if (p == 2 || p == 6)
            add_random_list(3, 1'b0);
         drain_phase();
      end

      if (mismatch_count == 0 && sorted_runs.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
